### rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE       = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR_RESET = 8'h07;

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row_v,
                                                   input logic [COL_W-1:0] col_v);
    logic [ADDR_W-1:0] acc;
    acc = ADDR_W'(row_v) * ADDR_W'(COLUMNS) + ADDR_W'(col_v);
    return acc;
  endfunction

endpackage

### rtl/text_console_writer_core.sv
// Text console writer: a screen of 80 x 25 cells of 16 bits (attribute in the
// high byte, character in the low byte) and a cursor.
// A request is taken at a rising edge where start is high and busy is low; the
// command and its fields are sampled at that edge. Busy stays high until the
// request is finished. Each request returns exactly one result, shown for one
// cycle with done_o high; the receiver cannot stall it and must take it then.
// Put char and set cursor finish in the execute state; a read cell also passes
// a read-wait state because the screen memory has a registered read port.
// Clear screen sweeps every cell through the single memory write port, one
// cell a cycle. A put char that scrolls copies the screen up one row and blanks
// the bottom row in one read-ahead sweep.
// A new request can be given in the cycle where done_o is high.
// The blank attribute register is written over its own channel, always ready;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset homes the cursor and sets the blank attribute to 7;
// the screen holds no defined contents until it is cleared or written.
module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [CHAR_W-1:0] color_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CHAR_W-1:0] cfg_data_i,
  output logic              done_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [ADDR_W-1:0] cursor_position_o,
  output logic              scrolled_o,
  output logic [CELL_W-1:0] cell_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] char_q, color_q, blank_q;
  logic [COL_W-1:0]  colin_q, cur_col_q, cur_col_d, col_clamp;
  logic [ROW_W-1:0]  rowin_q, cur_row_q, cur_row_d, row_clamp;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [COL_W:0]    nx_col;
  logic [ROW_W:0]    nx_row;
  logic [CELL_W-1:0] blank_cell;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              fin, fin_scr;
  logic [CELL_W-1:0] fin_cell;

  logic              done_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [ADDR_W-1:0] out_pos_q;
  logic              out_scr_q;
  logic [CELL_W-1:0] out_cell_q;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign blank_cell  = {blank_q, SPACE_CODE};

  assign col_clamp = (colin_q >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : colin_q;
  assign row_clamp = (rowin_q >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : rowin_q;

  always_comb begin
    state_d   = state_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(cur_row_q, cur_col_q);
    ram_wdata = {color_q, char_q};
    ram_raddr = cnt_q + ADDR_W'(COLUMNS);
    fin       = 1'b0;
    fin_scr   = 1'b0;
    fin_cell  = '0;
    nx_col    = {1'b0, cur_col_q};
    nx_row    = {1'b0, cur_row_q};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            if (char_q == NEWLINE_CODE) begin
              nx_col = '0;
              nx_row = {1'b0, cur_row_q} + 1'b1;
            end else begin
              ram_we = 1'b1;
              nx_col = {1'b0, cur_col_q} + 1'b1;
            end
            if (nx_col >= (COL_W+1)'(COLUMNS)) begin
              nx_col = '0;
              nx_row = nx_row + 1'b1;
            end
            cur_col_d = nx_col[COL_W-1:0];
            if (nx_row >= (ROW_W+1)'(ROWS)) begin
              cur_row_d = ROW_W'(ROWS - 1);
              cnt_d     = '0;
              state_d   = ST_SCROLL;
            end else begin
              cur_row_d = nx_row[ROW_W-1:0];
              fin       = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          CMD_CLEAR: begin
            cur_col_d = '0;
            cur_row_d = '0;
            cnt_d     = '0;
            state_d   = ST_CLEAR;
          end
          CMD_SET: begin
            cur_col_d = col_clamp;
            cur_row_d = row_clamp;
            fin       = 1'b1;
            state_d   = ST_IDLE;
          end
          default: begin
            ram_raddr = cell_addr(row_clamp, col_clamp);
            state_d   = ST_RDWAIT;
          end
        endcase
      end
      ST_RDWAIT: begin
        fin      = 1'b1;
        fin_cell = ram_rdata;
        state_d  = ST_IDLE;
      end
      ST_SCROLL: begin
        // The read runs one row ahead; the write uses the registered read data of the previous count.
        ram_waddr = cnt_q - 1'b1;
        ram_we    = (cnt_q != '0);
        ram_wdata = (cnt_q > ADDR_W'(CELL_COUNT - COLUMNS)) ? blank_cell : ram_rdata;
        if (cnt_q == ADDR_W'(CELL_COUNT)) begin
          fin     = 1'b1;
          fin_scr = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell;
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      cnt_q     <= '0;
      blank_q   <= BLANK_ATTR_RESET;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_q     <= cnt_d;
      done_q    <= fin;
      if (cfg_valid_i) begin
        blank_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cmd_q   <= cmd_i;
      char_q  <= char_code_i;
      color_q <= color_i;
      colin_q <= column_i;
      rowin_q <= row_i;
    end
    if (fin) begin
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_pos_q  <= cell_addr(cur_row_d, cur_col_d);
      out_scr_q  <= fin_scr;
      out_cell_q <= fin_cell;
    end
  end

  tcw_ram #(
    .Width(CELL_W),
    .Depth(CELL_COUNT)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign done_o            = done_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_position_o = out_pos_q;
  assign scrolled_o        = out_scr_q;
  assign cell_data_o       = out_cell_q;

endmodule

### rtl/tcw_ram.sv
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcw_checker.sv
module tcw_checker import tcw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [COL_W-1:0]  cursor_col_o,
  input logic [ROW_W-1:0]  cursor_row_o,
  input logic [ADDR_W-1:0] cursor_position_o,
  input logic              scrolled_o
);

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_pos_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cursor_position_o == cell_addr(cursor_row_o, cursor_col_o)))
    else $error("cursor position does not match row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cursor_col_o < COL_W'(COLUMNS)) && (cursor_row_o < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cursor_row_o == ROW_W'(ROWS - 1)))
    else $error("scroll left the cursor off the last row");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .cursor_col_o     (cursor_col_o),
  .cursor_row_o     (cursor_row_o),
  .cursor_position_o(cursor_position_o),
  .scrolled_o       (scrolled_o)
);
